// ===== sv/ssp_pkg.sv =====
// Shared types and constants for the shaded sphere pixel generator.
package ssp_pkg;

    // Field widths
    localparam int DIAM_W  = 10;
    localparam int INV_W   = 21;
    localparam int LIGHT_W = 16;
    localparam int PSIZE_W = 9;
    localparam int PM_W    = 19;
    localparam int XYL_W   = 39;

    // Configuration register indexes
    localparam logic [2:0] REG_DIAMETER     = 3'd0;
    localparam logic [2:0] REG_INV_DIAMETER = 3'd1;
    localparam logic [2:0] REG_LIGHT_X      = 3'd2;
    localparam logic [2:0] REG_LIGHT_Y      = 3'd3;
    localparam logic [2:0] REG_LIGHT_Z      = 3'd4;
    localparam logic [2:0] REG_PALETTE_SIZE = 3'd5;

    // Reset values
    localparam logic [DIAM_W-1:0]         DIAMETER_RST  = 10'd73;
    localparam logic [INV_W-1:0]          INV_RST       = 21'd14364;
    localparam logic signed [LIGHT_W-1:0] LIGHT_XY_RST  = 16'sd0;
    localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST   = 16'sd16384;
    localparam logic [PSIZE_W-1:0]        PSIZE_RST     = 9'd256;

    // Request kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    // Division by 1000: multiply by ceil(2^30/1000), shift by 30
    localparam logic [20:0] RECIP_1000  = 21'd1073742;
    localparam int          RECIP_SHIFT = 30;

    // Request payload carried along the pipeline
    typedef struct packed {
        logic              shade;
        logic              in_disc;
        logic [PSIZE_W-1:0] p;
        logic [PM_W-1:0]   pm;
        logic [7:0]        idx;
        logic [31:0]       wcolor;
    } item_t;

endpackage

// ===== sv/ssp_front.sv =====
// Disc test, normalized coordinates, light terms in x and y, and sqrt argument.
module ssp_front
    import ssp_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic                      in_cmd,
    input  logic [9:0]                in_row,
    input  logic [9:0]                in_column,
    input  logic [7:0]                in_idx,
    input  logic [31:0]               in_color,
    input  logic [DIAM_W-1:0]         diameter,
    input  logic [INV_W-1:0]          inv_diameter,
    input  logic signed [LIGHT_W-1:0] light_x,
    input  logic signed [LIGHT_W-1:0] light_y,
    input  logic [PSIZE_W-1:0]        palette_size,
    output logic                      out_vld,
    output item_t                     out_item,
    output logic [40:0]               out_s,
    output logic signed [XYL_W-1:0]   out_xyl
);

    localparam logic signed [21:0] ONE_Q20 = 22'sh100000;
    localparam logic signed [44:0] ONE_Q40 = 45'sh100_0000_0000;

    function automatic logic signed [21:0] sat_q20(input logic signed [34:0] v);
        if (v > 35'(ONE_Q20))
            return ONE_Q20;
        else if (v < -35'(ONE_Q20))
            return -ONE_Q20;
        else
            return v[21:0];
    endfunction

    logic [4:0] vld_reg;
    item_t      it1_reg, it2_reg, it3_reg, it4_reg, it5_reg;

    // stage 1: offsets from the center
    logic [10:0]        i2_c;
    logic signed [12:0] nx_c;
    logic signed [11:0] t_c, dy_c;
    logic [PSIZE_W-1:0] p_c;
    item_t              it_c;

    always_comb begin
        i2_c = {in_row, 1'b1};
        nx_c = $signed({2'b00, in_column, 1'b1}) - $signed({3'b000, diameter});
        t_c  = $signed({1'b0, diameter, 1'b0}) - $signed({1'b0, i2_c});
        dy_c = $signed({2'b00, diameter}) - $signed({1'b0, i2_c});
        if (palette_size == '0)
            p_c = 9'd1;
        else if (32'(palette_size) > 32'(PALETTE_DEPTH))
            p_c = 9'(PALETTE_DEPTH);
        else
            p_c = palette_size;
        it_c.shade   = in_cmd;
        it_c.in_disc = 1'b0;
        it_c.p       = p_c;
        it_c.pm      = ({10'd0, p_c} * 19'd1000) - 19'd1;
        it_c.idx     = in_idx;
        it_c.wcolor  = in_color;
    end

    logic signed [12:0] nx1_reg;
    logic [10:0]        i21_reg;
    logic signed [11:0] t1_reg, dy1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            it1_reg <= it_c;
            nx1_reg <= nx_c;
            i21_reg <= i2_c;
            t1_reg  <= t_c;
            dy1_reg <= dy_c;
        end
    end

    // stage 2: products for the disc test and the coordinates
    logic signed [25:0] nn2_reg;
    logic signed [23:0] q22_reg;
    logic signed [34:0] xr2_reg, yr2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            it2_reg <= it1_reg;
            nn2_reg <= 26'(nx1_reg) * 26'(nx1_reg);
            q22_reg <= $signed({1'b0, i21_reg}) * 24'(t1_reg);
            xr2_reg <= 35'(nx1_reg) * $signed({14'd0, inv_diameter});
            yr2_reg <= 35'(dy1_reg) * $signed({14'd0, inv_diameter});
        end
    end

    // stage 3: disc decision, saturate coordinates
    logic signed [21:0] x3_reg, y3_reg;
    item_t              it3_c;

    always_comb begin
        it3_c         = it2_reg;
        it3_c.in_disc = (q22_reg >= 0) && (nn2_reg <= 26'(q22_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it3_reg <= it3_c;
            x3_reg  <= sat_q20(xr2_reg);
            y3_reg  <= sat_q20(yr2_reg);
        end
    end

    // stage 4: squares and light products
    logic signed [43:0] xx4_reg, yy4_reg;
    logic signed [37:0] xl4_reg, yl4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            it4_reg <= it3_reg;
            xx4_reg <= 44'(x3_reg) * 44'(x3_reg);
            yy4_reg <= 44'(y3_reg) * 44'(y3_reg);
            xl4_reg <= 38'(x3_reg) * 38'(light_x);
            yl4_reg <= 38'(y3_reg) * 38'(light_y);
        end
    end

    // stage 5: sqrt argument clamped at zero, partial dot product
    logic signed [44:0] sd_c;
    logic [40:0]        s5_reg;
    logic signed [XYL_W-1:0] xyl5_reg;

    assign sd_c = ONE_Q40 - 45'(xx4_reg) - 45'(yy4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            it5_reg  <= it4_reg;
            s5_reg   <= (sd_c < 0) ? 41'd0 : sd_c[40:0];
            xyl5_reg <= XYL_W'(xl4_reg) + XYL_W'(yl4_reg);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    assign out_vld  = vld_reg[4];
    assign out_item = it5_reg;
    assign out_s    = s5_reg;
    assign out_xyl  = xyl5_reg;

endmodule

// ===== sv/ssp_sqrt.sv =====
// Pipelined integer square root, three result bits per stage.
module ssp_sqrt
    import ssp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_vld,
    input  item_t                   in_item,
    input  logic [40:0]             in_s,
    input  logic signed [XYL_W-1:0] in_xyl,
    output logic                    out_vld,
    output item_t                   out_item,
    output logic [20:0]             out_h,
    output logic signed [XYL_W-1:0] out_xyl
);

    localparam int STAGES    = 7;
    localparam int PER_STAGE = 3;

    typedef struct packed {
        logic [22:0] rem;
        logic [20:0] root;
    } sq_t;

    // one restoring step: bring down two bits, try root*4+1
    function automatic sq_t sqrt_step(input sq_t a, input logic [1:0] bits);
        logic [24:0] r2;
        logic [24:0] trial;
        sq_t         o;
        r2    = {a.rem, bits};
        trial = {2'b00, a.root, 2'b01};
        if (r2 >= trial) begin
            o.rem  = 23'(r2 - trial);
            o.root = {a.root[19:0], 1'b1};
        end else begin
            o.rem  = r2[22:0];
            o.root = {a.root[19:0], 1'b0};
        end
        return o;
    endfunction

    logic [STAGES-1:0]       vld_reg;
    item_t                   item_reg [STAGES];
    logic [41:0]             n_reg    [STAGES];
    sq_t                     acc_reg  [STAGES];
    logic signed [XYL_W-1:0] xyl_reg  [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic                    vld_in;
        item_t                   item_in;
        logic [41:0]             n_in, n_c;
        sq_t                     acc_in, acc_c;
        logic signed [XYL_W-1:0] xyl_in;

        if (g == 0) begin : g_first
            assign vld_in  = in_vld;
            assign item_in = in_item;
            assign n_in    = {1'b0, in_s};
            assign acc_in  = '0;
            assign xyl_in  = in_xyl;
        end else begin : g_next
            assign vld_in  = vld_reg[g-1];
            assign item_in = item_reg[g-1];
            assign n_in    = n_reg[g-1];
            assign acc_in  = acc_reg[g-1];
            assign xyl_in  = xyl_reg[g-1];
        end

        // three steps on the narrow remainder
        always_comb begin
            acc_c = acc_in;
            n_c   = n_in;
            for (int k = 0; k < PER_STAGE; k++) begin
                acc_c = sqrt_step(acc_c, n_c[41:40]);
                n_c   = {n_c[39:0], 2'b00};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                item_reg[g] <= item_in;
                n_reg[g]    <= n_c;
                acc_reg[g]  <= acc_c;
                xyl_reg[g]  <= xyl_in;
            end
        end
    end

    assign out_vld  = vld_reg[STAGES-1];
    assign out_item = item_reg[STAGES-1];
    assign out_h    = acc_reg[STAGES-1].root;
    assign out_xyl  = xyl_reg[STAGES-1];

endmodule

// ===== sv/ssp_back.sv =====
// Dot product completion, palette slot mapping and palette memory access.
module ssp_back
    import ssp_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_vld,
    input  item_t                     in_item,
    input  logic [20:0]               in_h,
    input  logic signed [XYL_W-1:0]   in_xyl,
    input  logic signed [LIGHT_W-1:0] light_z,
    output logic                      out_vld,
    output item_t                     out_item,
    output logic [7:0]                out_slot,
    output logic [31:0]               out_color
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic signed [40:0] ONE_Q34 = 41'sh4_0000_0000;
    localparam logic signed [40:0] TWO_Q34 = 41'sh8_0000_0000;

    logic [6:0] vld_reg;
    item_t      it1_reg, it2_reg, it3_reg, it4_reg, it5_reg, it6_reg, it7_reg;

    // stage 1: h times light z
    logic signed [37:0]      hl1_reg;
    logic signed [XYL_W-1:0] xyl1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            it1_reg  <= in_item;
            hl1_reg  <= $signed({17'd0, in_h}) * 38'(light_z);
            xyl1_reg <= in_xyl;
        end
    end

    // stage 2: full dot product
    logic signed [39:0] z2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            it2_reg <= it1_reg;
            z2_reg  <= 40'(xyl1_reg) + 40'(hl1_reg);
        end
    end

    // stage 3: offset by one and clamp to [0, 2]
    logic signed [40:0] zu_c;
    logic [35:0]        u3_reg;

    assign zu_c = 41'(z2_reg) + ONE_Q34;

    always_ff @(posedge aclk) begin
        if (en) begin
            it3_reg <= it2_reg;
            if (zu_c < 0)
                u3_reg <= 36'd0;
            else if (zu_c > TWO_Q34)
                u3_reg <= TWO_Q34[35:0];
            else
                u3_reg <= zu_c[35:0];
        end
    end

    // stage 4: partial products of (1000P-1)*u
    logic [36:0] plo4_reg, phi4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            it4_reg  <= it3_reg;
            plo4_reg <= 37'(it3_reg.pm) * 37'(u3_reg[17:0]);
            phi4_reg <= 37'(it3_reg.pm) * 37'(u3_reg[35:18]);
        end
    end

    // stage 5: combine and drop the 2^35 scale
    logic [54:0] a_c;
    logic [18:0] w5_reg;

    assign a_c = {phi4_reg, 18'd0} + 55'(plo4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            it5_reg <= it4_reg;
            w5_reg  <= a_c[53:35];
        end
    end

    // stage 6: divide by 1000 through the reciprocal
    logic [39:0] q6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            it6_reg <= it5_reg;
            q6_reg  <= 40'(w5_reg) * 40'(RECIP_1000);
        end
    end

    // stage 7: clamp slot, palette write or read in request order
    logic [9:0]         v_c;
    logic [PSIZE_W-1:0] vc_c;
    logic               we_c;
    logic [31:0]        ram [PALETTE_DEPTH];
    logic [31:0]        rdata_reg;
    logic [PSIZE_W-1:0] slot7_reg;

    always_comb begin
        v_c = q6_reg[RECIP_SHIFT+9:RECIP_SHIFT];
        if (v_c >= {1'b0, it6_reg.p})
            vc_c = it6_reg.p - 9'd1;
        else
            vc_c = v_c[8:0];
        we_c = vld_reg[5] && (it6_reg.shade == CMD_WRITE) &&
               (32'(it6_reg.idx) < 32'(PALETTE_DEPTH));
    end

    // single port: a write and a read never share a cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we_c)
                ram[AW'(it6_reg.idx)] <= it6_reg.wcolor;
            else
                rdata_reg <= ram[AW'(vc_c)];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it7_reg   <= it6_reg;
            slot7_reg <= vc_c;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    assign out_vld   = vld_reg[6];
    assign out_item  = it7_reg;
    assign out_slot  = slot7_reg[7:0];
    assign out_color = rdata_reg;

endmodule

// ===== sv/shaded_sphere_pixel_generator.sv =====
// Top level of the shaded sphere pixel generator: ports, registers, output stage.
//
// channel  | dir | handshake          | contents
// s_       | in  | s_tvalid/s_tready  | palette write or pixel shade request
// m_       | out | m_tvalid/m_tready  | one result per shade request
// apb      | in  | psel/penable       | six configuration registers
//
// One request per cycle while the pipeline is not stopped; a result passes through
// 5 front stages, 7 square root stages, 7 back stages and 1 output register.
// The palette is one single-port memory accessed in the seventh back stage.
// Reset clears valid bits and configuration registers; palette stays unknown.
// The pipeline stops only while a finished result waits in the output register
// and another result has reached the last stage.
module shaded_sphere_pixel_generator
    import ssp_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // row, column, entry_index, entry_color, zero fill
    input  logic        s_tuser,   // cmd
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // slot, pixel_color
    output logic        m_tuser,   // inside_res
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DIAM_W-1:0]         diameter_reg;
    logic [INV_W-1:0]          inv_reg;
    logic signed [LIGHT_W-1:0] lx_reg, ly_reg, lz_reg;
    logic [PSIZE_W-1:0]        psize_reg;

    // configuration writes
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diameter_reg <= DIAMETER_RST;
            inv_reg      <= INV_RST;
            lx_reg       <= LIGHT_XY_RST;
            ly_reg       <= LIGHT_XY_RST;
            lz_reg       <= LIGHT_Z_RST;
            psize_reg    <= PSIZE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_DIAMETER:     diameter_reg <= pwdata[9:0];
                REG_INV_DIAMETER: inv_reg      <= pwdata[20:0];
                REG_LIGHT_X:      lx_reg       <= pwdata[15:0];
                REG_LIGHT_Y:      ly_reg       <= pwdata[15:0];
                REG_LIGHT_Z:      lz_reg       <= pwdata[15:0];
                REG_PALETTE_SIZE: psize_reg    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            REG_DIAMETER:     prdata = {22'd0, diameter_reg};
            REG_INV_DIAMETER: prdata = {11'd0, inv_reg};
            REG_LIGHT_X:      prdata = 32'(lx_reg);
            REG_LIGHT_Y:      prdata = 32'(ly_reg);
            REG_LIGHT_Z:      prdata = 32'(lz_reg);
            REG_PALETTE_SIZE: prdata = {23'd0, psize_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // pipeline
    logic                    en;
    logic                    f_vld, q_vld, b_vld;
    item_t                   f_item, q_item, b_item;
    logic [40:0]             f_s;
    logic signed [XYL_W-1:0] f_xyl, q_xyl;
    logic [20:0]             q_h;
    logic [7:0]              b_slot;
    logic [31:0]             b_color;
    logic                    res_vld;
    logic                    m_tvalid_reg, m_tuser_reg;
    logic [39:0]             m_tdata_reg;

    ssp_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_vld       (s_tvalid && s_tready),
        .in_cmd       (s_tuser),
        .in_row       (s_tdata[9:0]),
        .in_column    (s_tdata[19:10]),
        .in_idx       (s_tdata[27:20]),
        .in_color     (s_tdata[59:28]),
        .diameter     (diameter_reg),
        .inv_diameter (inv_reg),
        .light_x      (lx_reg),
        .light_y      (ly_reg),
        .palette_size (psize_reg),
        .out_vld      (f_vld),
        .out_item     (f_item),
        .out_s        (f_s),
        .out_xyl      (f_xyl)
    );

    ssp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (f_vld),
        .in_item  (f_item),
        .in_s     (f_s),
        .in_xyl   (f_xyl),
        .out_vld  (q_vld),
        .out_item (q_item),
        .out_h    (q_h),
        .out_xyl  (q_xyl)
    );

    ssp_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (q_vld),
        .in_item   (q_item),
        .in_h      (q_h),
        .in_xyl    (q_xyl),
        .light_z   (lz_reg),
        .out_vld   (b_vld),
        .out_item  (b_item),
        .out_slot  (b_slot),
        .out_color (b_color)
    );

    // advance unless a waiting result would be overwritten
    assign res_vld  = b_vld && (b_item.shade == CMD_SHADE);
    assign en       = !m_tvalid_reg || m_tready || !res_vld;
    assign s_tready = en;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en && res_vld) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && res_vld) begin
            m_tuser_reg <= b_item.in_disc;
            m_tdata_reg <= b_item.in_disc ? {b_color, b_slot} : 40'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // no stall while the output register is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    // an outside pixel is transparent with slot zero
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tuser_reg |-> m_tdata_reg == 40'd0)
        else $error("outside pixel carries nonzero data");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid_reg)
        else $error("result valid right after reset");
`endif

endmodule
